// ----- rtl/cre_pkg.sv -----
// ----------------------------------------------------------------------------
// cre_pkg: shared types and constants for the colour register encoder
// Payload structs, register indexes and conversion constants.
// ----------------------------------------------------------------------------
package cre_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_TRUECOLOR   = 3'd0;
	localparam logic [2:0] REG_INVERT      = 3'd1;
	localparam logic [2:0] REG_GREY        = 3'd2;
	localparam logic [2:0] REG_PAL_ENTRIES = 3'd3;
	localparam logic [2:0] REG_RED_LAYOUT  = 3'd4;
	localparam logic [2:0] REG_GRN_LAYOUT  = 3'd5;
	localparam logic [2:0] REG_BLU_LAYOUT  = 3'd6;

	localparam int CFG_DATA_W = 10;

	localparam logic [9:0]  TRUE_COLOUR_SLOTS = 10'd16;
	localparam logic [15:0] GREY_WEIGHT_R     = 16'd19595;
	localparam logic [15:0] GREY_WEIGHT_G     = 16'd38470;
	localparam logic [15:0] GREY_WEIGHT_B     = 16'd7471;
	localparam logic [20:0] ROUND_BIAS        = 21'h7FFF;
	localparam logic [15:0] FULL_LEVEL        = 16'hFFFF;
	localparam logic [4:0]  MAX_FIELD_LEN     = 5'd16;

	// output target codes
	localparam logic TARGET_PSEUDO = 1'b0;
	localparam logic TARGET_HW_PAL = 1'b1;

	// status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic [9:0]  entry_number;
		logic [15:0] red_level;
		logic [15:0] green_level;
		logic [15:0] blue_level;
	} cre_req_t;

	typedef struct packed {
		logic        target_kind;
		logic [9:0]  entry_index;
		logic [31:0] packed_word;
		logic        status;
	} cre_res_t;

endpackage

// ----- rtl/colour_register_encoder.sv -----
// ----------------------------------------------------------------------------
// colour_register_encoder: colour request to colour register word
// Optional inversion and weighted grey, then true-colour field packing or
// rounded 4:4:4 palette word, with range check on the register number.
// ----------------------------------------------------------------------------
//  channel   | signals                            | transfer
//  ----------+------------------------------------+-------------------------
//  request   | start, busy, request               | start & !busy at clk
//  result    | result_valid, result               | one-cycle strobe
//  config    | cfg_write, cfg_index, cfg_data     | cfg_write at clk
//
// One beat is taken every cycle; busy is never raised.
// A beat passes the input register, the grey weight multipliers, then
// sum, packing and the result register.
// Reset clears the stage valids and loads the register defaults.
// Results cannot be held off, so the pipeline never stalls.
module colour_register_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cre_pkg::cre_req_t  request,
	output logic               result_valid,
	output cre_pkg::cre_res_t  result,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [9:0]         cfg_data
);
	import cre_pkg::*;

	logic       truecolor_q;
	logic       invert_q;
	logic       grey_q;
	logic [8:0] pal_entries_q;
	logic [9:0] red_layout_q;
	logic [9:0] grn_layout_q;
	logic [9:0] blu_layout_q;

	logic        valid_s1, valid_s2, valid_s3;
	logic [9:0]  num_s1, num_s2;
	logic [15:0] r_s1, g_s1, b_s1;
	logic [15:0] r_s2, g_s2, b_s2;
	logic [31:0] prod_r_s2, prod_g_s2, prod_b_s2;
	cre_res_t    res_s3;

	logic        accept;
	logic [31:0] grey_sum;
	logic [15:0] r_f, g_f, b_f;
	logic        ok;
	logic [31:0] word;
	cre_res_t    res_d;

	function automatic logic [31:0] place_channel(input logic [15:0] level,
			input logic [9:0] layout);
		logic [4:0]  len;
		logic [4:0]  shamt;
		logic [31:0] v;
		len = (layout[9:5] > MAX_FIELD_LEN) ? MAX_FIELD_LEN : layout[9:5];
		shamt = MAX_FIELD_LEN - len;
		v = {16'd0, level} >> shamt;
		return v << layout[4:0];
	endfunction

	function automatic logic [3:0] round_nibble(input logic [15:0] level);
		logic [20:0] t;
		t = {1'b0, level, 4'd0} + ROUND_BIAS - {5'd0, level};
		return t[19:16];
	endfunction

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			truecolor_q   <= 1'b1;
			invert_q      <= 1'b0;
			grey_q        <= 1'b0;
			pal_entries_q <= 9'd16;
			red_layout_q  <= 10'd136;
			grn_layout_q  <= 10'd132;
			blu_layout_q  <= 10'd128;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TRUECOLOR:   truecolor_q   <= cfg_data[0];
				REG_INVERT:      invert_q      <= cfg_data[0];
				REG_GREY:        grey_q        <= cfg_data[0];
				REG_PAL_ENTRIES: pal_entries_q <= cfg_data[8:0];
				REG_RED_LAYOUT:  red_layout_q  <= cfg_data;
				REG_GRN_LAYOUT:  grn_layout_q  <= cfg_data;
				REG_BLU_LAYOUT:  blu_layout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: capture, inversion folded in front of the register
	always_ff @(posedge clk) begin
		if (accept) begin
			num_s1 <= request.entry_number;
			r_s1   <= invert_q ? FULL_LEVEL - request.red_level   : request.red_level;
			g_s1   <= invert_q ? FULL_LEVEL - request.green_level : request.green_level;
			b_s1   <= invert_q ? FULL_LEVEL - request.blue_level  : request.blue_level;
		end
	end

	// stage 2: grey weights
	always_ff @(posedge clk) begin
		num_s2    <= num_s1;
		r_s2      <= r_s1;
		g_s2      <= g_s1;
		b_s2      <= b_s1;
		prod_r_s2 <= {16'd0, r_s1} * {16'd0, GREY_WEIGHT_R};
		prod_g_s2 <= {16'd0, g_s1} * {16'd0, GREY_WEIGHT_G};
		prod_b_s2 <= {16'd0, b_s1} * {16'd0, GREY_WEIGHT_B};
	end

	// weights sum to 65536, so the sum never wraps
	always_comb begin
		grey_sum = prod_r_s2 + prod_g_s2 + prod_b_s2;
		r_f = grey_q ? grey_sum[31:16] : r_s2;
		g_f = grey_q ? grey_sum[31:16] : g_s2;
		b_f = grey_q ? grey_sum[31:16] : b_s2;
		if (truecolor_q) begin
			ok   = num_s2 < TRUE_COLOUR_SLOTS;
			word = place_channel(r_f, red_layout_q) | place_channel(g_f, grn_layout_q)
				| place_channel(b_f, blu_layout_q);
		end else begin
			ok   = num_s2 < {1'b0, pal_entries_q};
			word = {20'd0, round_nibble(r_f), round_nibble(g_f), round_nibble(b_f)};
		end
		res_d.target_kind = truecolor_q ? TARGET_PSEUDO : TARGET_HW_PAL;
		res_d.entry_index = num_s2;
		res_d.packed_word = ok ? word : 32'd0;
		res_d.status      = ok ? STATUS_OK : STATUS_REJECT;
	end

	// stage 3: result register
	always_ff @(posedge clk) begin
		res_s3 <= res_d;
	end

	assign result_valid = valid_s3;
	assign result       = res_s3;

endmodule

// ----- rtl/cre_checker.sv -----
// ----------------------------------------------------------------------------
// cre_checker: port-level checks for the colour register encoder
// Latency, one result per beat and result word consistency.
// ----------------------------------------------------------------------------
module cre_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input cre_pkg::cre_req_t request,
	input logic              result_valid,
	input cre_pkg::cre_res_t result
);
	import cre_pkg::*;

	// every accepted beat comes out as a result through the pipeline registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 result_valid)
		else $error("accepted beat gave no result");

	// no result without a matching accepted beat
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, 3))
		else $error("result without request");

	// result echoes the request number
	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.entry_index == $past(request.entry_number, 3))
		else $error("entry index mismatch");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == STATUS_REJECT) |-> result.packed_word == 32'd0)
		else $error("rejected beat carries a word");

	// palette words are twelve bits; accepted true-colour numbers stay below 16
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == STATUS_OK) |->
		((result.target_kind == TARGET_HW_PAL && result.packed_word[31:12] == 20'd0) ||
		(result.target_kind == TARGET_PSEUDO && result.entry_index < 10'd16)))
		else $error("accepted result out of range");

endmodule

bind colour_register_encoder cre_checker u_cre_checker (.*);

// ----- tb/tb_colour_register_encoder.sv -----
// ----------------------------------------------------------------------------
// tb_colour_register_encoder: self-checking bench for the colour encoder
// A directed table (register settings and beats, some with hand-typed
// results) is followed by randomised phases, the first two with fixed
// register settings and the rest with random ones. Every result is checked
// field by field against its hand-typed result or a local predictor.
module tb_colour_register_encoder;
	import cre_pkg::*;

	localparam int          PIPE_DEPTH   = 3;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int          PHASES       = 12;
	localparam int          BEATS_PER_PH = 100;

	typedef struct packed {
		logic       truecolor;
		logic       invert;
		logic       grey;
		logic [8:0] pal_entries;
		logic [9:0] red_layout;
		logic [9:0] grn_layout;
		logic [9:0] blu_layout;
	} colour_cfg_t;

	localparam colour_cfg_t RESET_SETUP =
		'{1'b1, 1'b0, 1'b0, 9'd16, 10'd136, 10'd132, 10'd128};

	typedef enum logic {ROW_SETUP, ROW_BEAT} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		colour_cfg_t setup;
		cre_req_t    req;
		logic        typed;
		cre_res_t    want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cre_req_t    request = '0;
	logic        result_valid;
	cre_res_t    result;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;

	colour_cfg_t colour_setup;
	cre_res_t    pending_results[$];
	dir_row_t    dir_rows[$];
	int          error_count = 0;
	int          idle_pct = 0;
	int unsigned cycle_count = 0;

	colour_register_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t  timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---- predictor ----

	function automatic logic [31:0] place_field(input logic [15:0] level,
			input logic [9:0] layout);
		int unsigned len;
		logic [63:0] wide;
		len = layout[9:5];
		if (len > 16)
			len = 16;
		wide = 64'(level) >> (16 - len);
		wide = wide << layout[4:0];
		return wide[31:0];
	endfunction

	function automatic logic [3:0] round_nibble(input logic [15:0] level);
		logic [31:0] acc;
		acc = ({16'd0, level} << 4) + 32'(ROUND_BIAS) - {16'd0, level};
		return acc[19:16];
	endfunction

	function automatic cre_res_t encode_colour(input colour_cfg_t c, input cre_req_t q);
		logic [15:0] r, g, b;
		logic [31:0] luma, word;
		logic        ok;
		cre_res_t    res;
		r = q.red_level;
		g = q.green_level;
		b = q.blue_level;
		if (c.invert) begin
			r = FULL_LEVEL - r;
			g = FULL_LEVEL - g;
			b = FULL_LEVEL - b;
		end
		if (c.grey) begin
			// weights sum to 65536, so the sum never leaves 32 bits
			luma = 32'(GREY_WEIGHT_R) * 32'(r) + 32'(GREY_WEIGHT_G) * 32'(g)
				+ 32'(GREY_WEIGHT_B) * 32'(b);
			r = luma[31:16];
			g = r;
			b = r;
		end
		if (c.truecolor) begin
			ok   = q.entry_number < TRUE_COLOUR_SLOTS;
			word = place_field(r, c.red_layout) | place_field(g, c.grn_layout)
				| place_field(b, c.blu_layout);
		end else begin
			ok   = q.entry_number < {1'b0, c.pal_entries};
			word = {20'd0, round_nibble(r), round_nibble(g), round_nibble(b)};
		end
		res.target_kind = c.truecolor ? TARGET_PSEUDO : TARGET_HW_PAL;
		res.entry_index = q.entry_number;
		res.packed_word = ok ? word : 32'd0;
		res.status      = ok ? STATUS_OK : STATUS_REJECT;
		return res;
	endfunction

	// ---- result checking ----

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t  %s mismatch: expected %h, got %h", $time, field, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		cre_res_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t  unexpected result: expected none, got %h", $time, result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("target_kind", 32'(want.target_kind), 32'(result.target_kind));
				check_field("entry_index", 32'(want.entry_index), 32'(result.entry_index));
				check_field("packed_word", want.packed_word, result.packed_word);
				check_field("status", 32'(want.status), 32'(result.status));
			end
		end
	end

	// ---- stimulus ----

	function automatic void add_setup(input colour_cfg_t s);
		dir_row_t row;
		row.kind  = ROW_SETUP;
		row.setup = s;
		row.req   = '0;
		row.typed = 1'b0;
		row.want  = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_beat(input logic [9:0] n, input logic [15:0] r,
			input logic [15:0] g, input logic [15:0] b, input logic typed,
			input logic kind, input logic [31:0] word, input logic st);
		dir_row_t row;
		row.kind  = ROW_BEAT;
		row.setup = '0;
		row.req   = '{n, r, g, b};
		row.typed = typed;
		row.want  = '{kind, n, word, st};
		dir_rows.push_back(row);
	endfunction

	function automatic logic [15:0] pick_level();
		unique case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h7fff;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [9:0] random_layout();
		logic [4:0] len;
		len = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
		return {len, 5'($urandom_range(31))};
	endfunction

	// called at a rising edge; returns at the edge that took the beat
	task automatic send_beat(input cre_req_t q, input logic typed, input cre_res_t want);
		while ($urandom_range(99) < idle_pct) begin
			start   <= 1'b0;
			request <= cre_req_t'(58'({$urandom(), $urandom()}));
			@(posedge clk);
		end
		request <= q;
		start   <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(typed ? want : encode_colour(colour_setup, q));
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
	endtask

	task automatic apply_setup(input colour_cfg_t s);
		logic [9:0] d;
		colour_setup = s;
		for (int i = 0; i < 7; i++) begin
			unique case (3'(i))
				REG_TRUECOLOR:   d = {9'd0, s.truecolor};
				REG_INVERT:      d = {9'd0, s.invert};
				REG_GREY:        d = {9'd0, s.grey};
				REG_PAL_ENTRIES: d = {1'b0, s.pal_entries};
				REG_RED_LAYOUT:  d = s.red_layout;
				REG_GRN_LAYOUT:  d = s.grn_layout;
				default:         d = s.blu_layout;
			endcase
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= d;
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	initial begin
		colour_cfg_t s;
		cre_req_t q;
		int bound;

		colour_setup = RESET_SETUP;

		// straight after reset: 4:4:4 true-colour packing of the top nibbles
		add_beat(10'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1, TARGET_PSEUDO, 32'h0, STATUS_OK);
		add_beat(10'd15, 16'hffff, 16'hffff, 16'hffff, 1'b1, TARGET_PSEUDO, 32'hfff, STATUS_OK);
		add_beat(10'd16, 16'hffff, 16'hffff, 16'hffff, 1'b1, TARGET_PSEUDO, 32'h0,
			STATUS_REJECT);
		add_beat(10'd1023, 16'h1234, 16'h5678, 16'h9abc, 1'b1, TARGET_PSEUDO, 32'h0,
			STATUS_REJECT);
		add_beat(10'd5, 16'hffff, 16'h0000, 16'h0000, 1'b1, TARGET_PSEUDO, 32'hf00, STATUS_OK);
		add_beat(10'd7, 16'h0000, 16'hffff, 16'h0000, 1'b1, TARGET_PSEUDO, 32'h0f0, STATUS_OK);
		add_beat(10'd3, 16'h1234, 16'h5678, 16'h9abc, 1'b1, TARGET_PSEUDO, 32'h159, STATUS_OK);
		add_beat(10'h2aa, 16'h0000, 16'h0000, 16'hffff, 1'b0, TARGET_PSEUDO, 32'h0, STATUS_OK);

		// inverted; green length saturates at 16, blue length zero
		add_setup('{1'b1, 1'b1, 1'b0, 9'd16, 10'd528, 10'd992, 10'd0});
		add_beat(10'd2, 16'h0000, 16'hffff, 16'h1234, 1'b1, TARGET_PSEUDO, 32'hffff0000,
			STATUS_OK);
		add_beat(10'd9, 16'h00ff, 16'h0f0f, 16'hf000, 1'b0, TARGET_PSEUDO, 32'h0, STATUS_OK);

		// grey, fields running past bit 31
		add_setup('{1'b1, 1'b0, 1'b1, 9'd16, 10'd543, 10'd284, 10'd1023});
		add_beat(10'd15, 16'hffff, 16'hffff, 16'hffff, 1'b1, TARGET_PSEUDO, 32'hf0000000,
			STATUS_OK);
		add_beat(10'd4, 16'hffff, 16'h0000, 16'h0000, 1'b0, TARGET_PSEUDO, 32'h0, STATUS_OK);

		// empty palette rejects everything
		add_setup('{1'b0, 1'b0, 1'b0, 9'd0, 10'd136, 10'd132, 10'd128});
		add_beat(10'd0, 16'h8000, 16'h8000, 16'h8000, 1'b1, TARGET_HW_PAL, 32'h0,
			STATUS_REJECT);

		add_setup('{1'b0, 1'b1, 1'b0, 9'd256, 10'd136, 10'd132, 10'd128});
		add_beat(10'd255, 16'h0000, 16'h0000, 16'h0000, 1'b1, TARGET_HW_PAL, 32'hfff,
			STATUS_OK);
		add_beat(10'd256, 16'h0000, 16'h0000, 16'h0000, 1'b1, TARGET_HW_PAL, 32'h0,
			STATUS_REJECT);
		add_beat(10'd100, 16'h8000, 16'h0800, 16'h1234, 1'b0, TARGET_HW_PAL, 32'h0, STATUS_OK);

		// palette size beyond 256 is taken as written
		add_setup('{1'b0, 1'b0, 1'b1, 9'd511, 10'd136, 10'd132, 10'd128});
		add_beat(10'd510, 16'h4321, 16'hfedc, 16'h0101, 1'b0, TARGET_HW_PAL, 32'h0, STATUS_OK);
		add_beat(10'd511, 16'hffff, 16'hffff, 16'hffff, 1'b1, TARGET_HW_PAL, 32'h0,
			STATUS_REJECT);
		add_beat(10'd1023, 16'hffff, 16'hffff, 16'hffff, 1'b1, TARGET_HW_PAL, 32'h0,
			STATUS_REJECT);

		// nibble rounding
		add_setup('{1'b0, 1'b0, 1'b0, 9'd16, 10'd136, 10'd132, 10'd128});
		add_beat(10'd15, 16'h0000, 16'h0800, 16'h1000, 1'b0, TARGET_HW_PAL, 32'h0, STATUS_OK);
		add_beat(10'd0, 16'hffff, 16'hffff, 16'hffff, 1'b1, TARGET_HW_PAL, 32'hfff, STATUS_OK);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 27;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_SETUP) begin
				settle();
				apply_setup(dir_rows[i].setup);
			end else begin
				send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				s = '{1'b1, 1'b1, 1'b1, 9'd511, 10'd1023, 10'd1023, 10'd1023};
			end else if (ph == 1) begin
				s = '{1'b1, 1'b0, 1'b0, 9'd0, 10'd0, 10'd0, 10'd0};
			end else begin
				s.truecolor = 1'($urandom_range(1));
				s.invert    = 1'($urandom_range(1));
				s.grey      = 1'($urandom_range(1));
				case ($urandom_range(3))
					0: s.pal_entries = 9'd256;
					1: s.pal_entries = 9'd511;
					2: s.pal_entries = 9'($urandom_range(1, 16));
					default: s.pal_entries = 9'($urandom_range(511));
				endcase
				s.red_layout = random_layout();
				s.grn_layout = random_layout();
				s.blu_layout = random_layout();
			end
			settle();
			apply_setup(s);
			idle_pct = (ph < 4) ? 27 : ((ph < 8) ? 51 : 0);
			bound = s.truecolor ? 16 : int'(s.pal_entries);
			repeat (BEATS_PER_PH) begin
				// with a non-empty range, half the numbers are drawn inside it so at least half the beats produce a word
				if (bound != 0 && $urandom_range(1) == 1)
					q.entry_number = 10'($urandom_range(bound - 1));
				else
					q.entry_number = 10'($urandom_range(1023));
				q.red_level   = pick_level();
				q.green_level = pick_level();
				q.blue_level  = pick_level();
				send_beat(q, 1'b0, '0);
			end
		end

		settle();
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cre_pkg.sv
rtl/colour_register_encoder.sv
rtl/cre_checker.sv
tb/tb_colour_register_encoder.sv
